// ===== rtl/morse_key_decoder_assert.svh =====
// Assertion macros for the Morse key decoder.
// Used by the top level; define ASSERT_OFF to compile them out.
`ifndef MORSE_KEY_DECODER_ASSERT_SVH
`define MORSE_KEY_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define MKD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MKD_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MKD_ASSERT(label, clk, rst_n, prop, msg)
`define MKD_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/mkd_pkg.sv =====
// Shared types, constants and the letter table of the Morse key decoder.
// No dependencies; used by mkd_step and morse_key_decoder.
package mkd_pkg;

    localparam int unsigned TICK_W     = 13;
    localparam int unsigned MIN_W      = 10;
    localparam int unsigned FLASH_W    = 7;
    localparam int unsigned COUNT_W    = 3;
    localparam int unsigned SYM_W      = 5;
    localparam int unsigned WORD_W     = 7;
    localparam int unsigned INDEX_W    = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned LETTER_COUNT = 26;

    localparam logic [TICK_W-1:0]  PRESS_CAP    = 13'd5000;
    localparam logic [TICK_W-1:0]  RELEASE_TOP  = 13'd5000;
    localparam logic [TICK_W-1:0]  RELEASE_HOLD = 13'd4999;
    localparam logic [WORD_W-1:0]  WORD_LIMIT   = 7'd64;
    localparam logic [WORD_W-1:0]  WORD_SAT     = 7'd127;
    localparam logic [COUNT_W-1:0] SYM_LIMIT    = 3'd5;
    localparam logic [COUNT_W-1:0] SYM_LAST_POS = 3'd4;
    localparam logic [INDEX_W-1:0] LAST_LETTER  = 5'd25;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_GAP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_LEN = 3'd4;

    localparam logic [MIN_W-1:0]   RST_MIN_PRESS = 10'd10;
    localparam logic [TICK_W-1:0]  RST_DOT_MAX   = 13'd300;
    localparam logic [TICK_W-1:0]  RST_CHAR_GAP  = 13'd500;
    localparam logic [TICK_W-1:0]  RST_WORD_GAP  = 13'd2000;
    localparam logic [FLASH_W-1:0] RST_FLASH_LEN = 7'd100;

    // bits 7..5 symbol count, bits 4..0 symbols (dot = 1, first at bit 4)
    localparam logic [7:0] LETTER_CODES [LETTER_COUNT] = '{
        8'h50, 8'h8E, 8'h8A, 8'h6C, 8'h30, 8'h9A, 8'h64, 8'h9E, 8'h58, 8'h90,
        8'h68, 8'h96, 8'h40, 8'h48, 8'h60, 8'h92, 8'h84, 8'h74, 8'h7C, 8'h20,
        8'h78, 8'h9C, 8'h70, 8'h8C, 8'h88, 8'h86
    };

    typedef struct packed {
        logic [MIN_W-1:0]   min_press;
        logic [TICK_W-1:0]  dot_max;
        logic [TICK_W-1:0]  char_gap;
        logic [TICK_W-1:0]  word_gap;
        logic [FLASH_W-1:0] flash_len;
    } t_cfg;

    typedef struct packed {
        logic [TICK_W-1:0]  press_ticks;
        logic [TICK_W-1:0]  release_ticks;
        logic [COUNT_W-1:0] symbol_count;
        logic [SYM_W-1:0]   symbol_bits;
        logic [WORD_W-1:0]  letters_in_word;
        logic [FLASH_W-1:0] flash_count;
    } t_state;

    typedef struct packed {
        logic               led_on;
        logic               letter_valid;
        logic [INDEX_W-1:0] letter_index;
        logic               word_end;
    } t_result;

    typedef struct packed {
        logic               hit;
        logic [INDEX_W-1:0] index;
    } t_lookup;

    function automatic t_lookup letter_lookup(input logic [7:0] code);
        t_lookup res;
        res = '0;
        for (int i = 0; i < LETTER_COUNT; i++) begin
            if (!res.hit && LETTER_CODES[i] == code) begin
                res.hit   = 1'b1;
                res.index = INDEX_W'(i);
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/mkd_step.sv =====
// Next-state and result logic for one key sample of the Morse key decoder.
// Depends on mkd_pkg; purely combinational, registered by the top level.
module mkd_step (
    input  mkd_pkg::t_cfg    i_cfg,
    input  mkd_pkg::t_state  i_state,
    input  logic             i_key_down,
    output mkd_pkg::t_state  o_state,
    output mkd_pkg::t_result o_result
);

    logic                            sym_hit;
    logic [mkd_pkg::COUNT_W-1:0]     sc1;
    logic [mkd_pkg::SYM_W-1:0]       sb1;
    logic [mkd_pkg::TICK_W-1:0]      rel1;
    logic [mkd_pkg::TICK_W-1:0]      press1;
    logic                            end_full;
    logic                            end_gap;
    logic                            end_any;
    mkd_pkg::t_lookup                look;
    logic                            hit;
    logic [mkd_pkg::WORD_W-1:0]      liw1;
    logic                            word_br;
    logic [mkd_pkg::FLASH_W-1:0]     flash1;
    mkd_pkg::t_state                 n_state;

    assign sym_hit = i_state.press_ticks >= {3'd0, i_cfg.min_press};
    assign sc1     = sym_hit ? i_state.symbol_count + 3'd1 : i_state.symbol_count;
    assign sb1     = (sym_hit && i_state.press_ticks <= i_cfg.dot_max
                      && i_state.symbol_count <= mkd_pkg::SYM_LAST_POS)
                   ? (i_state.symbol_bits | (5'b10000 >> i_state.symbol_count))
                   : i_state.symbol_bits;
    assign rel1    = (i_state.release_ticks < mkd_pkg::RELEASE_TOP)
                   ? i_state.release_ticks + 13'd1 : i_state.release_ticks;
    assign press1  = (i_state.press_ticks < mkd_pkg::PRESS_CAP)
                   ? i_state.press_ticks + 13'd1 : i_state.press_ticks;

    assign end_full = !i_key_down && sym_hit && sc1 == mkd_pkg::SYM_LIMIT;
    assign end_gap  = !i_key_down && !end_full && sc1 != '0 && rel1 >= i_cfg.char_gap;
    assign end_any  = end_full || end_gap;
    assign look     = mkd_pkg::letter_lookup({sc1, sb1});
    assign hit      = end_any && look.hit;
    assign liw1     = (hit && i_state.letters_in_word < mkd_pkg::WORD_SAT)
                    ? i_state.letters_in_word + 7'd1 : i_state.letters_in_word;
    assign word_br  = !i_key_down && !end_gap
                    && (rel1 >= i_cfg.word_gap || liw1 >= mkd_pkg::WORD_LIMIT);

    always_comb begin
        n_state = i_state;
        if (i_key_down) begin
            n_state.release_ticks = '0;
            n_state.press_ticks   = press1;
            if (press1 >= i_cfg.dot_max) begin
                n_state.flash_count = 7'd1;
            end
        end else begin
            n_state.press_ticks     = '0;
            n_state.release_ticks   = (rel1 >= mkd_pkg::RELEASE_TOP)
                                    ? mkd_pkg::RELEASE_HOLD : rel1;
            n_state.symbol_count    = end_any ? '0 : sc1;
            n_state.symbol_bits     = end_any ? '0 : sb1;
            n_state.letters_in_word = (word_br && liw1 != '0) ? '0 : liw1;
            if (word_br) begin
                n_state.flash_count = 7'd1;
            end else if (end_any) begin
                n_state.flash_count = i_cfg.flash_len;
            end
        end
        flash1 = n_state.flash_count;
        if (flash1 != '0) begin
            n_state.flash_count = flash1 - 7'd1;
        end
    end

    assign o_state               = n_state;
    assign o_result.led_on       = flash1 != '0;
    assign o_result.letter_valid = hit;
    assign o_result.letter_index = hit ? look.index : '0;
    assign o_result.word_end     = word_br && liw1 != '0;

endmodule

// ===== rtl/morse_key_decoder.sv =====
// Morse key decoder top level: config registers, state register, output skid.
// Depends on mkd_pkg, mkd_step and morse_key_decoder_assert.svh.
//
// Takes one key sample per item and returns exactly one result item per sample.
// Throughput is one item per clock while o_in_stall is low: the full timing,
// symbol and letter-table step is a single combinational pass between the state
// register and the output register. A two-deep output stage (output register plus
// skid register) lets the input keep flowing for one extra item while the output
// is stalled; o_in_stall rises only when both are full. Configuration writes take
// effect on the next accepted item and are meant to be done while the block is idle.
`include "morse_key_decoder_assert.svh"

module morse_key_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_key_down,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_led_on,
    output logic                              o_letter_valid,
    output logic [mkd_pkg::INDEX_W-1:0]       o_letter_index,
    output logic                              o_word_end,
    input  logic                              i_cfg_we,
    input  logic [mkd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mkd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    mkd_pkg::t_cfg    r_cfg;
    mkd_pkg::t_state  r_state;
    mkd_pkg::t_state  n_state;
    mkd_pkg::t_result n_result;
    mkd_pkg::t_result r_out;
    mkd_pkg::t_result r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;
    logic             in_acc;
    logic             out_take;

    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    mkd_step u_step (
        .i_cfg      (r_cfg),
        .i_state    (r_state),
        .i_key_down (i_key_down),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_press <= mkd_pkg::RST_MIN_PRESS;
            r_cfg.dot_max   <= mkd_pkg::RST_DOT_MAX;
            r_cfg.char_gap  <= mkd_pkg::RST_CHAR_GAP;
            r_cfg.word_gap  <= mkd_pkg::RST_WORD_GAP;
            r_cfg.flash_len <= mkd_pkg::RST_FLASH_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mkd_pkg::CFG_MIN_PRESS: r_cfg.min_press <= i_cfg_data[mkd_pkg::MIN_W-1:0];
                mkd_pkg::CFG_DOT_MAX:   r_cfg.dot_max   <= i_cfg_data;
                mkd_pkg::CFG_CHAR_GAP:  r_cfg.char_gap  <= i_cfg_data;
                mkd_pkg::CFG_WORD_GAP:  r_cfg.word_gap  <= i_cfg_data;
                mkd_pkg::CFG_FLASH_LEN: r_cfg.flash_len <= i_cfg_data[mkd_pkg::FLASH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_acc) begin
            if (r_out_valid && !out_take) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_led_on       = r_out.led_on;
    assign o_letter_valid = r_out.letter_valid;
    assign o_letter_index = r_out.letter_index;
    assign o_word_end     = r_out.word_end;

    `MKD_ASSERT_NEVER(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid && !r_out_valid, "skid holds an item while output register is empty")
    `MKD_ASSERT(a_fill_skid, i_clk, i_rst_n, (in_acc && r_out_valid && i_out_stall) |=> r_skid_valid, "item accepted under stall not parked in skid")
    `MKD_ASSERT_NEVER(a_symbol_count, i_clk, i_rst_n, r_state.symbol_count > mkd_pkg::SYM_LAST_POS, "symbol count past four between items")
    `MKD_ASSERT_NEVER(a_tick_range, i_clk, i_rst_n, r_state.release_ticks > mkd_pkg::RELEASE_HOLD || r_state.press_ticks > mkd_pkg::PRESS_CAP, "tick counter out of range")
    `MKD_ASSERT_NEVER(a_letter_range, i_clk, i_rst_n, o_out_valid && o_letter_valid && o_letter_index > mkd_pkg::LAST_LETTER, "letter index past Z")

endmodule
